// File: hdl/vaos_pkg.sv
// Shared constants, codes and beat types for the voice allocator.
package vaos_pkg;

   localparam int NUM_VOICES = 16;
   localparam int PAD_COUNT  = 16;

   localparam int IDX_W = $clog2(NUM_VOICES);
   localparam int CNT_W = $clog2(NUM_VOICES + 1);
   localparam int PAD_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
   localparam int AGE_W = 64;
   localparam int ENTRY_W = PAD_W + AGE_W;

   // request codes
   localparam logic [1:0] REQ_TRIGGER  = 2'd0;
   localparam logic [1:0] REQ_KILL_PAD = 2'd1;
   localparam logic [1:0] REQ_KILL_ALL = 2'd2;
   localparam logic [1:0] REQ_DONE     = 2'd3;

   // status codes
   localparam logic [1:0] ST_FREE   = 2'd0;
   localparam logic [1:0] ST_STOLEN = 2'd1;
   localparam logic [1:0] ST_REJECT = 2'd2;
   localparam logic [1:0] ST_OTHER  = 2'd3;

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] pad_index;
      logic       sample_valid;
      logic [3:0] done_voice;
   } vaos_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  voice_index;
      logic [15:0] release_mask;
      logic [4:0]  active_count;
   } vaos_rsp_type;

endpackage

// File: hdl/vaos_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module vaos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/voice_allocator_oldest_steal_unit.sv
// A request sweeps the voice RAM when it is a valid trigger with every voice busy
// or a kill-pad request; other requests go straight to the response state.
// Throughput: one request at a time; busy stays high until the result strobe.
// The sweep reads one pad/age entry per cycle from the single RAM read port.
// Reset (synchronous): all voices inactive, age counter zero, no RAM clearing.
// Results cannot be stalled; each result is shown for exactly one cycle.
module voice_allocator_oldest_steal_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  vaos_pkg::vaos_req_type req_item,
   output logic                  rsp_valid,
   output vaos_pkg::vaos_rsp_type rsp_item
);
   import vaos_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_FINISH = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

   logic [2:0]            state_ff, state_in;
   vaos_req_type          req_ff, req_in;
   logic [NUM_VOICES-1:0] active_ff, active_in;
   logic [AGE_W-1:0]      age_ff, age_in;
   logic [IDX_W-1:0]      scan_addr_ff, scan_addr_in;
   logic                  scan_issue_ff, scan_issue_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [AGE_W-1:0]      best_age_ff, best_age_in;
   logic [NUM_VOICES-1:0] mask_ff, mask_in;
   logic [1:0]            status_ff, status_in;
   logic [IDX_W-1:0]      vidx_ff, vidx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   vaos_rsp_type          rsp_ff, rsp_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic                  rd_en;
   logic [ENTRY_W-1:0]    rd_data;
   logic [PAD_W-1:0]      rd_pad;
   logic [AGE_W-1:0]      rd_age;

   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic [CNT_W-1:0]      active_cnt;
   logic                  trig_ok;
   logic                  done_ok;
   logic [IDX_W-1:0]      done_idx;
   logic [AGE_W-1:0]      age_next;
   logic [IDX_W+3:0]      vidx_ext;
   logic [CNT_W+4:0]      cnt_ext;

   vaos_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(NUM_VOICES)
   ) u_voice_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(scan_addr_ff),
      .rd_data(rd_data)
   );

   assign rd_pad = rd_data[ENTRY_W-1:AGE_W];
   assign rd_age = rd_data[AGE_W-1:0];

   // lowest-numbered inactive voice
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_VOICES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   always_comb begin
      active_cnt = '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
         active_cnt = active_cnt + CNT_W'(active_ff[i]);
      end
   end

   assign trig_ok  = req_ff.sample_valid && (6'(req_ff.pad_index) < 6'(PAD_COUNT));
   assign done_ok  = 7'(req_ff.done_voice) < 7'(NUM_VOICES);
   assign done_idx = IDX_W'(req_ff.done_voice);
   assign age_next = age_ff + AGE_W'(1);
   assign vidx_ext = (IDX_W + 4)'(vidx_ff);
   assign cnt_ext  = (CNT_W + 5)'(active_cnt);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      active_in     = active_ff;
      age_in        = age_ff;
      scan_addr_in  = scan_addr_ff;
      scan_issue_in = scan_issue_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = scan_addr_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      mask_in       = mask_ff;
      status_in     = status_ff;
      vidx_in       = vidx_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = free_idx;
      wr_data       = {PAD_W'(req_ff.pad_index), age_next};
      rd_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            mask_in       = '0;
            vidx_in       = '0;
            status_in     = ST_OTHER;
            scan_addr_in  = '0;
            scan_issue_in = 1'b0;
            state_in      = S_RESP;
            case (req_ff.req_type)
               REQ_TRIGGER: begin
                  if (!trig_ok) begin
                     status_in = ST_REJECT;
                  end else if (free_found) begin
                     wr_en               = 1'b1;
                     active_in[free_idx] = 1'b1;
                     age_in              = age_next;
                     vidx_in             = free_idx;
                     status_in           = ST_FREE;
                  end else begin
                     scan_issue_in = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               REQ_KILL_PAD: begin
                  scan_issue_in = 1'b1;
                  state_in      = S_SCAN;
               end
               REQ_KILL_ALL: begin
                  active_in = '0;
               end
               default: begin
                  if (done_ok) begin
                     active_in[done_idx] = 1'b0;
                  end
               end
            endcase
         end
         S_SCAN: begin
            if (scan_issue_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               if (scan_addr_ff == LAST_IDX) begin
                  scan_issue_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff + IDX_W'(1);
               end
            end
            if (rd_valid_ff) begin
               if (req_ff.req_type == REQ_TRIGGER) begin
                  // strict compare keeps the lowest index on equal ages
                  if (rd_idx_ff == '0 || rd_age < best_age_ff) begin
                     best_idx_in = rd_idx_ff;
                     best_age_in = rd_age;
                  end
               end else if (active_ff[rd_idx_ff] &&
                            (5'(rd_pad) == req_ff.pad_index)) begin
                  mask_in[rd_idx_ff] = 1'b1;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (req_ff.req_type == REQ_TRIGGER) begin
               wr_en                  = 1'b1;
               wr_addr                = best_idx_ff;
               active_in[best_idx_ff] = 1'b1;
               age_in                 = age_next;
               vidx_in                = best_idx_ff;
               status_in              = ST_STOLEN;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_in.status       = status_ff;
            rsp_in.voice_index  = vidx_ext[3:0];
            rsp_in.active_count = cnt_ext[4:0];
            for (int i = 0; i < 16; i++) begin
               rsp_in.release_mask[i] = (i < NUM_VOICES) ? mask_ff[i % NUM_VOICES] : 1'b0;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= '0;
         age_ff        <= '0;
         scan_issue_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         age_ff        <= age_in;
         scan_issue_ff <= scan_issue_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      best_idx_ff  <= best_idx_in;
      best_age_ff  <= best_age_in;
      mask_ff      <= mask_in;
      status_ff    <= status_in;
      vidx_ff      <= vidx_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_RESP))
      else $error("result strobe without a response state");

   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("request finished without a result beat");

   a_steal_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && req_ff.req_type == REQ_TRIGGER) |-> (&active_ff))
      else $error("voice stolen while a free voice existed");

endmodule
